### sv/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the rational root search unit
// Payload structs of both channels, datapath opcodes and the control/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rrs_pkg;

    // defaults for the top-level parameters
    localparam int MAX_DEGREE_DEF = 7;
    localparam int COEF_BITS_DEF  = 8;

    // fixed field widths of the channels
    localparam int COEF_IN_BITS = 8;
    localparam int POWER_BITS   = 3;
    localparam int FRAC_BITS    = 8;
    localparam int COUNT_BITS   = 3;

    // exact evaluation width and root cap
    localparam int                  EVAL_BITS = 64;
    localparam logic [COUNT_BITS-1:0] MAX_ROOTS = 3'd7;

    // one coefficient transaction
    typedef struct packed {
        logic signed [COEF_IN_BITS-1:0] coefficient;
        logic [POWER_BITS-1:0]          power;
        logic                           last_coefficient;
    } coef_in_t;

    // one result transaction
    typedef struct packed {
        logic [FRAC_BITS-1:0]  numerator;
        logic [FRAC_BITS-1:0]  denominator;
        logic                  negative;
        logic                  is_root;
        logic [COUNT_BITS-1:0] root_count;
        logic                  done_res;
    } result_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_SCAN,
        OP_MOD_P,
        OP_MOD_Q,
        OP_MOD_G,
        OP_MOD_STEP,
        OP_GCD_INIT,
        OP_GCD_NEXT,
        OP_Q_INIT,
        OP_Q_NEXT,
        OP_P_NEXT,
        OP_EVAL_POS,
        OP_EVAL_NEG,
        OP_EVAL_MUL,
        OP_EVAL_ADD,
        OP_EMIT_ROOT,
        OP_EMIT_DONE
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        op_t  op;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic any_nz;
        logic mod_last;
        logic rem_zero;
        logic gb_zero;
        logic ga_one;
        logic p_last;
        logic q_last;
        logic k_at_lo;
        logic acc_zero;
        logic room;
        logic out_free;
        logic neg;
    } dp_stat_t;

endpackage

### sv/rrs_ctrl.sv
// ----------------------------------------------------------------------------
// rrs_ctrl: search sequencer
// Walks the load, scan, divisor, gcd, evaluation and emit steps and drives
// the datapath command; some steps issue no operation.
// ----------------------------------------------------------------------------
module rrs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              coef_valid,
    input  logic              coef_last,
    output logic              coef_ready,
    input  rrs_pkg::dp_stat_t stat,
    output rrs_pkg::dp_cmd_t  cmd
);
    import rrs_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_SCAN   = 20'h00002,
        S_SETUP  = 20'h00004,
        S_PSTART = 20'h00008,
        S_PMOD   = 20'h00010,
        S_PCHK   = 20'h00020,
        S_QSTART = 20'h00040,
        S_QMOD   = 20'h00080,
        S_QCHK   = 20'h00100,
        S_GCHK   = 20'h00200,
        S_GMOD   = 20'h00400,
        S_GNEXT  = 20'h00800,
        S_EVLOOP = 20'h01000,
        S_EVADD  = 20'h02000,
        S_EVTEST = 20'h04000,
        S_EMIT   = 20'h08000,
        S_SNEXT  = 20'h10000,
        S_QNEXT  = 20'h20000,
        S_PNEXT  = 20'h40000,
        S_DONE   = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign coef_ready = (state_reg == S_IDLE);

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = coef_valid;
                if (coef_valid && coef_last)
                begin
                    cmd.op     = OP_CLEAR;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (stat.scan_last)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = stat.any_nz ? S_PSTART : S_DONE;
            end
            S_PSTART:
            begin
                cmd.op     = OP_MOD_P;
                state_next = S_PMOD;
            end
            S_PMOD:
            begin
                cmd.op = OP_MOD_STEP;
                if (stat.mod_last)
                begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (stat.rem_zero)
                begin
                    cmd.op     = OP_Q_INIT;
                    state_next = S_QSTART;
                end
                else
                begin
                    state_next = S_PNEXT;
                end
            end
            S_QSTART:
            begin
                cmd.op     = OP_MOD_Q;
                state_next = S_QMOD;
            end
            S_QMOD:
            begin
                cmd.op = OP_MOD_STEP;
                if (stat.mod_last)
                begin
                    state_next = S_QCHK;
                end
            end
            S_QCHK:
            begin
                if (stat.rem_zero)
                begin
                    cmd.op     = OP_GCD_INIT;
                    state_next = S_GCHK;
                end
                else
                begin
                    state_next = S_QNEXT;
                end
            end
            S_GCHK:
            begin
                if (!stat.gb_zero)
                begin
                    cmd.op     = OP_MOD_G;
                    state_next = S_GMOD;
                end
                else if (stat.ga_one)
                begin
                    cmd.op     = OP_EVAL_POS;
                    state_next = S_EVLOOP;
                end
                else
                begin
                    state_next = S_QNEXT;
                end
            end
            S_GMOD:
            begin
                cmd.op = OP_MOD_STEP;
                if (stat.mod_last)
                begin
                    state_next = S_GNEXT;
                end
            end
            S_GNEXT:
            begin
                cmd.op     = OP_GCD_NEXT;
                state_next = S_GCHK;
            end
            S_EVLOOP:
            begin
                if (stat.k_at_lo)
                begin
                    state_next = S_EVTEST;
                end
                else
                begin
                    cmd.op     = OP_EVAL_MUL;
                    state_next = S_EVADD;
                end
            end
            S_EVADD:
            begin
                cmd.op     = OP_EVAL_ADD;
                state_next = S_EVLOOP;
            end
            S_EVTEST:
            begin
                state_next = (stat.acc_zero && stat.room) ? S_EMIT : S_SNEXT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_ROOT;
                    state_next = S_SNEXT;
                end
            end
            S_SNEXT:
            begin
                if (!stat.neg)
                begin
                    cmd.op     = OP_EVAL_NEG;
                    state_next = S_EVLOOP;
                end
                else
                begin
                    state_next = S_QNEXT;
                end
            end
            S_QNEXT:
            begin
                if (stat.q_last)
                begin
                    state_next = S_PNEXT;
                end
                else
                begin
                    cmd.op     = OP_Q_NEXT;
                    state_next = S_QSTART;
                end
            end
            S_PNEXT:
            begin
                if (stat.p_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_P_NEXT;
                    state_next = S_PSTART;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sv/rrs_dp.sv
// ----------------------------------------------------------------------------
// rrs_dp: search datapath
// Coefficient store, divisor counters, shared restoring remainder unit,
// homogeneous Horner evaluator and the result register.
// ----------------------------------------------------------------------------
module rrs_dp #(
    parameter int MAX_DEGREE = rrs_pkg::MAX_DEGREE_DEF,
    parameter int COEF_BITS  = rrs_pkg::COEF_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rrs_pkg::dp_cmd_t  cmd,
    input  rrs_pkg::coef_in_t coef_data,
    output rrs_pkg::dp_stat_t stat,
    input  logic              res_ready,
    output logic              res_valid,
    output rrs_pkg::result_t  res_data
);
    import rrs_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(COEF_BITS);

    // coefficient store and search bookkeeping
    logic signed [COEF_BITS-1:0] store_reg [DEPTH];
    logic                        any_nz_reg;
    logic [COUNT_BITS-1:0]       roots_reg;
    logic                        res_valid_reg;

    // payload registers
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            lo_reg;
    logic [IDX_W-1:0]            hi_reg;
    logic [IDX_W-1:0]            k_reg;
    logic [COEF_BITS-1:0]        alo_reg;
    logic [COEF_BITS-1:0]        ahi_reg;
    logic [COEF_BITS-1:0]        p_reg;
    logic [COEF_BITS-1:0]        q_reg;
    logic [COEF_BITS-1:0]        ga_reg;
    logic [COEF_BITS-1:0]        gb_reg;
    logic [COEF_BITS-1:0]        mod_a_reg;
    logic [COEF_BITS-1:0]        mod_b_reg;
    logic [COEF_BITS-1:0]        mod_rem_reg;
    logic [CNT_W-1:0]            mod_cnt_reg;
    logic                        neg_reg;
    logic signed [EVAL_BITS-1:0] acc_reg;
    logic signed [EVAL_BITS-1:0] qpow_reg;
    result_t                     res_reg;

    // combinational helpers
    logic [IDX_W-1:0]            rd_idx;
    logic signed [COEF_BITS-1:0] rd_coef;
    logic [COEF_BITS-1:0]        rd_abs;
    logic                        wr_ok;
    logic [COEF_BITS:0]          mod_shift;
    logic                        mod_ge;
    logic [COEF_BITS-1:0]        mod_rem_new;
    logic signed [COEF_BITS:0]   p_ext;
    logic signed [COEF_BITS:0]   x_val;
    logic signed [EVAL_BITS-1:0] acc_mul;
    logic signed [EVAL_BITS-1:0] qpow_mul;
    logic signed [EVAL_BITS-1:0] term;
    logic                        out_free;

    // single read port of the store
    always_comb
    begin
        unique case (cmd.op)
            OP_EVAL_POS, OP_EVAL_NEG: rd_idx = hi_reg;
            OP_EVAL_ADD:              rd_idx = k_reg;
            default:                  rd_idx = idx_reg;
        endcase
    end

    assign rd_coef = store_reg[rd_idx];
    assign rd_abs  = rd_coef[COEF_BITS-1] ? COEF_BITS'(-rd_coef) : COEF_BITS'(rd_coef);
    assign wr_ok   = cmd.load && (int'(coef_data.power) <= MAX_DEGREE);

    // one restoring remainder step
    assign mod_shift   = {mod_rem_reg, mod_a_reg[COEF_BITS-1]};
    assign mod_ge      = mod_shift >= {1'b0, mod_b_reg};
    assign mod_rem_new = mod_ge ? COEF_BITS'(mod_shift - {1'b0, mod_b_reg})
                                : COEF_BITS'(mod_shift);

    // evaluator arithmetic, x = +-p
    assign p_ext    = $signed({1'b0, p_reg});
    assign x_val    = neg_reg ? -p_ext : p_ext;
    assign acc_mul  = acc_reg * EVAL_BITS'(x_val);
    assign qpow_mul = qpow_reg * $signed(EVAL_BITS'(q_reg));
    assign term     = EVAL_BITS'(rd_coef) * qpow_reg;

    assign out_free = !res_valid_reg || res_ready;

    // store, root count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
            any_nz_reg    <= 1'b0;
            roots_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                store_reg[IDX_W'(coef_data.power)] <= coef_data.coefficient[COEF_BITS-1:0];
            end
            // output valid: set by an emit, cleared when taken
            if (cmd.op == OP_EMIT_ROOT || cmd.op == OP_EMIT_DONE)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_CLEAR:
                begin
                    any_nz_reg <= 1'b0;
                    roots_reg  <= '0;
                end
                OP_SCAN:
                begin
                    if (rd_coef != '0)
                    begin
                        any_nz_reg <= 1'b1;
                    end
                end
                OP_EMIT_ROOT:
                begin
                    roots_reg <= roots_reg + 1'b1;
                end
                OP_EMIT_DONE:
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        store_reg[i] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_CLEAR:
            begin
                idx_reg <= '0;
                p_reg   <= COEF_BITS'(1);
            end
            OP_SCAN:
            begin
                idx_reg <= idx_reg + 1'b1;
                if (rd_coef != '0)
                begin
                    if (!any_nz_reg)
                    begin
                        lo_reg  <= idx_reg;
                        alo_reg <= rd_abs;
                    end
                    hi_reg  <= idx_reg;
                    ahi_reg <= rd_abs;
                end
            end
            OP_MOD_P, OP_MOD_Q, OP_MOD_G:
            begin
                mod_rem_reg <= '0;
                mod_cnt_reg <= '0;
                if (cmd.op == OP_MOD_P)
                begin
                    mod_a_reg <= alo_reg;
                    mod_b_reg <= p_reg;
                end
                else if (cmd.op == OP_MOD_Q)
                begin
                    mod_a_reg <= ahi_reg;
                    mod_b_reg <= q_reg;
                end
                else
                begin
                    mod_a_reg <= ga_reg;
                    mod_b_reg <= gb_reg;
                end
            end
            OP_MOD_STEP:
            begin
                mod_rem_reg <= mod_rem_new;
                mod_a_reg   <= mod_a_reg << 1;
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            OP_GCD_INIT:
            begin
                ga_reg <= p_reg;
                gb_reg <= q_reg;
            end
            OP_GCD_NEXT:
            begin
                ga_reg <= gb_reg;
                gb_reg <= mod_rem_reg;
            end
            OP_Q_INIT:
            begin
                q_reg <= COEF_BITS'(1);
            end
            OP_Q_NEXT:
            begin
                q_reg <= q_reg + 1'b1;
            end
            OP_P_NEXT:
            begin
                p_reg <= p_reg + 1'b1;
            end
            OP_EVAL_POS, OP_EVAL_NEG:
            begin
                acc_reg  <= EVAL_BITS'(rd_coef);
                qpow_reg <= EVAL_BITS'(1);
                k_reg    <= hi_reg;
                neg_reg  <= (cmd.op == OP_EVAL_NEG);
            end
            OP_EVAL_MUL:
            begin
                acc_reg  <= acc_mul;
                qpow_reg <= qpow_mul;
                k_reg    <= k_reg - 1'b1;
            end
            OP_EVAL_ADD:
            begin
                acc_reg <= acc_reg + term;
            end
            OP_EMIT_ROOT:
            begin
                res_reg.numerator   <= FRAC_BITS'(p_reg);
                res_reg.denominator <= FRAC_BITS'(q_reg);
                res_reg.negative    <= neg_reg;
                res_reg.is_root     <= 1'b1;
                res_reg.root_count  <= roots_reg + 1'b1;
                res_reg.done_res    <= 1'b0;
            end
            OP_EMIT_DONE:
            begin
                res_reg.numerator   <= '0;
                res_reg.denominator <= '0;
                res_reg.negative    <= 1'b0;
                res_reg.is_root     <= 1'b0;
                res_reg.root_count  <= roots_reg;
                res_reg.done_res    <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // status back to the controller
    assign stat.scan_last = (idx_reg == IDX_W'(MAX_DEGREE));
    assign stat.any_nz    = any_nz_reg;
    assign stat.mod_last  = (mod_cnt_reg == CNT_W'(COEF_BITS - 1));
    assign stat.rem_zero  = (mod_rem_reg == '0);
    assign stat.gb_zero   = (gb_reg == '0);
    assign stat.ga_one    = (ga_reg == COEF_BITS'(1));
    assign stat.p_last    = (p_reg == alo_reg);
    assign stat.q_last    = (q_reg == ahi_reg);
    assign stat.k_at_lo   = (k_reg == lo_reg);
    assign stat.acc_zero  = (acc_reg == '0);
    assign stat.room      = (roots_reg != MAX_ROOTS);
    assign stat.out_free  = out_free;
    assign stat.neg       = neg_reg;

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

### sv/rational_root_search_unit.sv
// ----------------------------------------------------------------------------
// rational_root_search_unit: rational root search over an integer polynomial
// Loads coefficients one per transaction and reports nonzero reduced rational
// roots +-p/q up to MAX_ROOTS, then a done transaction with the root count.
// ----------------------------------------------------------------------------
// Usage:
//  coef channel (coef_valid/coef_ready/coef_data): one coefficient per
//  transaction, written at its power; a power above MAX_DEGREE is dropped.
//  The transaction marked last_coefficient starts the search; coef_ready
//  stays low until the done transaction has been placed in the output
//  register, then the store is already clear.
//  res channel (res_valid/res_ready/res_data): root transactions in the order
//  p ascending, q ascending, plus before minus, then one done transaction.
//  Search steps: a scan of the store, then per p candidate and per q
//  candidate of each divisor p a start, COEF_BITS steps of the shared
//  remainder unit, a check and an advance; per divisor pair the gcd
//  passes; per sign a Horner evaluation, one more step to emit a root.
//  The bit-serial remainder unit sets the length of the search.
//  If res_ready is low, the search holds when it has the next transaction
//  ready, until the output register frees up.
//  Reset (rst_n low, asynchronous) clears the store, the root count and the
//  output valid, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module rational_root_search_unit #(
    parameter int MAX_DEGREE = rrs_pkg::MAX_DEGREE_DEF,
    parameter int COEF_BITS  = rrs_pkg::COEF_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              coef_valid,
    output logic              coef_ready,
    input  rrs_pkg::coef_in_t coef_data,
    output logic              res_valid,
    input  logic              res_ready,
    output rrs_pkg::result_t  res_data
);
    import rrs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    rrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_last  (coef_data.last_coefficient),
        .coef_ready (coef_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath
    rrs_dp #(
        .MAX_DEGREE (MAX_DEGREE),
        .COEF_BITS  (COEF_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .coef_data (coef_data),
        .stat      (stat),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

endmodule

### sv/rrs_checker.sv
// ----------------------------------------------------------------------------
// rrs_checker: port-level checks of the rational root search unit
// Watches both channels and tracks search progress and root numbering.
// ----------------------------------------------------------------------------
module rrs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              coef_valid,
    input logic              coef_ready,
    input rrs_pkg::coef_in_t coef_data,
    input logic              res_valid,
    input logic              res_ready,
    input rrs_pkg::result_t  res_data
);
    import rrs_pkg::*;

    logic                  pending_reg;
    logic [COUNT_BITS-1:0] cnt_reg;

    // search in flight and roots accepted so far
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (coef_valid && coef_ready && coef_data.last_coefficient)
            begin
                pending_reg <= 1'b1;
            end
            else if (res_valid && res_data.done_res)
            begin
                pending_reg <= 1'b0;
            end
            if (res_valid && res_ready)
            begin
                cnt_reg <= res_data.done_res ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    // a stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // the last coefficient closes the input for the search
    a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && coef_ready && coef_data.last_coefficient |=> !coef_ready)
        else $error("input open right after search start");

    // no new coefficient before the done transaction shows up
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg && !(res_valid && res_data.done_res) |-> !coef_ready)
        else $error("input open during search");

    // roots are numbered one by one, done repeats the count
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |->
            res_data.root_count == (res_data.done_res ? cnt_reg : cnt_reg + 1'b1))
        else $error("root count out of sequence");

endmodule

bind rational_root_search_unit rrs_checker u_rrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef_valid (coef_valid),
    .coef_ready (coef_ready),
    .coef_data  (coef_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
);
